// ----- hdl/har_pkg.sv -----
// ----------------------------------------------------------------------------
// har_pkg: shared constants, types and helpers of the Hermite resampler
// Default parameter values, the width of the step register, the job control
// struct that travels from the front part to the back part, and width helpers.
// ----------------------------------------------------------------------------
package har_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_UPSAMPLE_DEF = 16;

    // rate_step register: unsigned Q8.FRAC_BITS
    localparam int STEP_W = 24;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // control part of one interval job
    typedef struct packed {
        logic [1:0] rest;       // intervals of the same beat still to follow
        logic       flush_end;  // last interval of a buffer: clear position after it
    } job_ctl_t;

    localparam int JOB_CTL_W = $bits(job_ctl_t);

    // fraction bits kept for the interpolation
    function automatic int t_bits(input int sample_bits, input int frac_bits);
        int lim;
        begin
            lim = (56 - sample_bits) / 2;
            return (frac_bits < lim) ? frac_bits : lim;
        end
    endfunction

    // position accumulator width: holds position plus one step
    function automatic int pos_w(input int frac_bits);
        begin
            return ((STEP_W > frac_bits + 1) ? STEP_W : frac_bits + 1) + 1;
        end
    endfunction

    // job payload: here sample, k1, k2, k3
    function automatic int job_data_w(input int sample_bits);
        begin
            return sample_bits + (sample_bits + 1) + 2 * (sample_bits + 4);
        end
    endfunction

endpackage

// ----- hdl/har_if.sv -----
// ----------------------------------------------------------------------------
// har_if: sample and result stream interfaces
// Valid/ready channels; a beat moves at a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface har_in_if import har_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          end_of_buffer;

    modport source (output valid, output in_sample, output end_of_buffer, input ready);
    modport sink   (input valid, input in_sample, input end_of_buffer, output ready);
endinterface

interface har_out_if import har_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          run_last;

    modport source (output valid, output out_sample, output run_last, input ready);
    modport sink   (input valid, input out_sample, input run_last, output ready);
endinterface

// ----- hdl/har_front.sv -----
// ----------------------------------------------------------------------------
// har_front: sample intake and interval job builder
// Keeps the sample history, and for each beat emits zero to three interval
// jobs (neighbor coefficients plus control) toward the job queue.
// ----------------------------------------------------------------------------
module har_front import har_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    har_in_if.sink                                 samples,
    output logic                                   job_valid,
    input  logic                                   job_ready,
    output job_ctl_t                               job_ctl,
    output logic [job_data_w(SAMPLE_BITS)-1:0]     job_data
);

    localparam int S   = SAMPLE_BITS;
    localparam int K_W = S + 4;

    logic signed [S-1:0] hist0_reg, hist1_reg, hist2_reg, hist3_reg;
    logic [1:0]          seen_reg;
    logic [1:0]          snap_seen_reg;
    logic [1:0]          d_reg;
    logic                eob_reg;
    logic                pend_reg;

    logic                accept;
    logic                push;
    logic signed [S-1:0] left, here, right, far;
    logic signed [K_W-1:0] l_x, h_x, r_x, f_x, hr_x;
    logic signed [S:0]     k1;
    logic signed [K_W-1:0] k2, k3;

    assign samples.ready = !pend_reg;
    assign accept        = samples.valid && !pend_reg;
    assign push          = pend_reg && job_ready;
    assign job_valid     = pend_reg;

    // pick the four neighbors of the interval d samples behind the newest
    always_comb
    begin
        case (d_reg)
            2'd2:
            begin
                here  = hist2_reg;
                right = hist1_reg;
                far   = hist0_reg;
                left  = (snap_seen_reg >= 2'd3) ? hist3_reg : hist2_reg;
            end
            2'd1:
            begin
                here  = hist1_reg;
                right = hist0_reg;
                far   = hist0_reg;
                left  = (snap_seen_reg >= 2'd2) ? hist2_reg : hist1_reg;
            end
            2'd0:
            begin
                here  = hist0_reg;
                right = hist0_reg;
                far   = hist0_reg;
                left  = (snap_seen_reg >= 2'd1) ? hist1_reg : hist0_reg;
            end
            default:
            begin
                here  = '0;
                right = '0;
                far   = '0;
                left  = '0;
            end
        endcase
    end

    assign l_x  = K_W'(left);
    assign h_x  = K_W'(here);
    assign r_x  = K_W'(right);
    assign f_x  = K_W'(far);
    assign hr_x = h_x - r_x;

    assign k1 = (S + 1)'(right) - (S + 1)'(left);
    assign k2 = (l_x <<< 1) - ((h_x <<< 2) + h_x) + (r_x <<< 2) - f_x;
    assign k3 = (f_x - l_x) + (hr_x <<< 1) + hr_x;

    assign job_ctl.rest      = eob_reg ? d_reg : 2'd0;
    assign job_ctl.flush_end = eob_reg && (d_reg == 2'd0);
    assign job_data          = {here, k1, k2, k3};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            hist2_reg     <= '0;
            hist3_reg     <= '0;
            seen_reg      <= '0;
            snap_seen_reg <= '0;
            d_reg         <= '0;
            eob_reg       <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (accept)
        begin
            hist0_reg     <= samples.in_sample;
            hist1_reg     <= hist0_reg;
            hist2_reg     <= hist1_reg;
            hist3_reg     <= hist2_reg;
            snap_seen_reg <= seen_reg;
            eob_reg       <= samples.end_of_buffer;
            pend_reg      <= samples.end_of_buffer || (seen_reg >= 2'd2);
            if (samples.end_of_buffer)
            begin
                d_reg <= (seen_reg >= 2'd2) ? 2'd2 : seen_reg;
            end
            else
            begin
                d_reg <= 2'd2;
                if (seen_reg != 2'd3)
                begin
                    seen_reg <= seen_reg + 2'd1;
                end
            end
        end
        else if (push)
        begin
            if (!eob_reg)
            begin
                pend_reg <= 1'b0;
            end
            else if (d_reg == 2'd0)
            begin
                // buffer done: drop history, restart
                pend_reg  <= 1'b0;
                hist0_reg <= '0;
                hist1_reg <= '0;
                hist2_reg <= '0;
                hist3_reg <= '0;
                seen_reg  <= '0;
            end
            else
            begin
                d_reg <= d_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/har_queue.sv -----
// ----------------------------------------------------------------------------
// har_queue: short job queue
// Flip-flop FIFO that decouples the job builder from the interpolation back end.
// ----------------------------------------------------------------------------
module har_queue import har_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/har_back.sv -----
// ----------------------------------------------------------------------------
// har_back: position walker and Hermite evaluation pipeline
// Walks the output position through each interval job and evaluates the
// cubic in Horner form over a stalling pipeline ending in the output register.
// ----------------------------------------------------------------------------
module har_back import har_pkg::*; #(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [STEP_W-1:0]                  rate_step,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  job_ctl_t                           job_ctl,
    input  logic [job_data_w(SAMPLE_BITS)-1:0] job_data,
    har_out_if.source                          results
);

    localparam int S     = SAMPLE_BITS;
    localparam int F     = FRAC_BITS;
    localparam int T     = t_bits(SAMPLE_BITS, FRAC_BITS);
    localparam int P_W   = pos_w(FRAC_BITS);
    localparam int K_W   = S + 4;
    localparam int A1_W  = K_W + T + 1;
    localparam int M1_W  = A1_W + T + 1;
    localparam int A2_W  = A1_W + 1;
    localparam int M2_W  = A2_W + T + 1;
    localparam int R2_W  = M2_W + 1 - (2 * T + 1);
    localparam int SUM_W = R2_W + 1;

    localparam logic [P_W-1:0] ONE_POS  = P_W'(1) << F;
    localparam logic [P_W-1:0] MIN_STEP = P_W'(((64'd1 << F) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);
    localparam logic signed [M1_W:0] HALF1 = (M1_W + 1)'(1) <<< (T - 1);
    localparam logic signed [M2_W:0] HALF2 = (M2_W + 1)'(1) <<< (2 * T);
    localparam logic signed [SUM_W-1:0] SMP_MAX = SUM_W'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SMP_MIN = -SMP_MAX - SUM_W'(1);

    // job fields
    logic signed [S-1:0]   j_here;
    logic signed [S:0]     j_k1;
    logic signed [K_W-1:0] j_k2, j_k3;

    // walker
    logic [P_W-1:0] pos_reg, pos_next;
    logic [P_W-1:0] step_eff, pos_sum, last_lim;
    logic           adv, in_span, span_end, issue;

    // stage 0: issued point
    logic                  s0_valid_reg, s0_last_reg;
    logic [T-1:0]          s0_t_reg;
    logic signed [S-1:0]   s0_here_reg;
    logic signed [S:0]     s0_k1_reg;
    logic signed [K_W-1:0] s0_k2_reg, s0_k3_reg;
    // stage 1: a1
    logic                  s1_valid_reg, s1_last_reg;
    logic [T-1:0]          s1_t_reg;
    logic signed [S-1:0]   s1_here_reg;
    logic signed [S:0]     s1_k1_reg;
    logic signed [A1_W-1:0] s1_a1_reg;
    // stage 2: a1 * t
    logic                  s2_valid_reg, s2_last_reg;
    logic [T-1:0]          s2_t_reg;
    logic signed [S-1:0]   s2_here_reg;
    logic signed [S:0]     s2_k1_reg;
    logic signed [M1_W-1:0] s2_m1_reg;
    // stage 3: a2
    logic                  s3_valid_reg, s3_last_reg;
    logic [T-1:0]          s3_t_reg;
    logic signed [S-1:0]   s3_here_reg;
    logic signed [A2_W-1:0] s3_a2_reg;
    // stage 4: a2 * t
    logic                  s4_valid_reg, s4_last_reg;
    logic signed [S-1:0]   s4_here_reg;
    logic signed [M2_W-1:0] s4_m2_reg;
    // output register
    logic                  out_valid_reg, out_last_reg;
    logic signed [S-1:0]   out_sample_reg;

    logic signed [T:0]       t0_s, t1_s, t3_s;
    logic signed [A1_W-1:0]  p_k3t, a1_next;
    logic signed [M1_W-1:0]  m1_next;
    logic signed [M1_W:0]    w1;
    logic signed [A2_W-1:0]  a2_next;
    logic signed [M2_W-1:0]  m2_next;
    logic signed [M2_W:0]    w2;
    logic signed [R2_W-1:0]  r2;
    logic signed [SUM_W-1:0] sum;
    logic signed [S-1:0]     y_next;

    assign {j_here, j_k1, j_k2, j_k3} = job_data;

    // ---------------- walker ----------------
    assign adv      = !out_valid_reg || results.ready;
    assign step_eff = (P_W'(rate_step) < MIN_STEP) ? MIN_STEP : P_W'(rate_step);
    assign pos_sum  = pos_reg + step_eff;
    assign in_span  = pos_reg < ONE_POS;
    assign span_end = pos_sum >= ONE_POS;
    assign last_lim = (P_W'(job_ctl.rest) + P_W'(1)) << F;
    assign issue    = adv && job_valid && in_span;
    assign job_ready = adv && (!in_span || span_end);

    always_comb
    begin
        pos_next = pos_reg;
        if (adv && job_valid)
        begin
            if (in_span && !span_end)
            begin
                pos_next = pos_sum;
            end
            else if (job_ctl.flush_end)
            begin
                pos_next = '0;
            end
            else if (in_span)
            begin
                pos_next = pos_sum - ONE_POS;
            end
            else
            begin
                pos_next = pos_reg - ONE_POS;
            end
        end
    end

    // ---------------- arithmetic ----------------
    assign t0_s    = $signed({1'b0, s0_t_reg});
    assign t1_s    = $signed({1'b0, s1_t_reg});
    assign t3_s    = $signed({1'b0, s3_t_reg});

    assign p_k3t   = s0_k3_reg * t0_s;
    assign a1_next = p_k3t + (A1_W'(s0_k2_reg) <<< T);

    assign m1_next = s1_a1_reg * t1_s;

    assign w1      = (M1_W + 1)'(s2_m1_reg) + HALF1;
    assign a2_next = A2_W'(w1 >>> T) + (A2_W'(s2_k1_reg) <<< T);

    assign m2_next = s3_a2_reg * t3_s;

    assign w2      = (M2_W + 1)'(s4_m2_reg) + HALF2;
    assign r2      = R2_W'(w2 >>> (2 * T + 1));
    assign sum     = SUM_W'(r2) + SUM_W'(s4_here_reg);

    always_comb
    begin
        if (sum > SMP_MAX)
        begin
            y_next = SMP_MAX[S-1:0];
        end
        else if (sum < SMP_MIN)
        begin
            y_next = SMP_MIN[S-1:0];
        end
        else
        begin
            y_next = sum[S-1:0];
        end
    end

    // ---------------- payload stages ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_last_reg    <= pos_sum >= last_lim;
            s0_t_reg       <= pos_reg[F-1 -: T];
            s0_here_reg    <= j_here;
            s0_k1_reg      <= j_k1;
            s0_k2_reg      <= j_k2;
            s0_k3_reg      <= j_k3;

            s1_last_reg    <= s0_last_reg;
            s1_t_reg       <= s0_t_reg;
            s1_here_reg    <= s0_here_reg;
            s1_k1_reg      <= s0_k1_reg;
            s1_a1_reg      <= a1_next;

            s2_last_reg    <= s1_last_reg;
            s2_t_reg       <= s1_t_reg;
            s2_here_reg    <= s1_here_reg;
            s2_k1_reg      <= s1_k1_reg;
            s2_m1_reg      <= m1_next;

            s3_last_reg    <= s2_last_reg;
            s3_t_reg       <= s2_t_reg;
            s3_here_reg    <= s2_here_reg;
            s3_a2_reg      <= a2_next;

            s4_last_reg    <= s3_last_reg;
            s4_here_reg    <= s3_here_reg;
            s4_m2_reg      <= m2_next;

            out_last_reg   <= s4_last_reg;
            out_sample_reg <= y_next;
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (adv)
            begin
                s0_valid_reg  <= issue;
                s1_valid_reg  <= s0_valid_reg;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_sample = out_sample_reg;
    assign results.run_last   = out_last_reg;

endmodule

// ----- hdl/hermite_audio_resampler.sv -----
// ----------------------------------------------------------------------------
// hermite_audio_resampler: streaming four-point cubic Hermite resampler
// Takes audio samples of a buffer and emits interpolated samples at every
// multiple of rate_step, flushing the tail at end_of_buffer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  --------  ---  ------------------  ----------------------------------------
//  samples   in   valid / ready       in_sample (signed), end_of_buffer
//  results   out  valid / ready       out_sample (signed, saturated), run_last
//  cfg       in   cfg_wr_en           cfg_wr_data -> rate_step (Q8.FRAC_BITS)
//
//  Flow: the front takes a beat, then takes no new beat until it has pushed
//  each interval job of that beat (none or one per ordinary beat, up to three
//  at end of buffer). While the output is not stalled, the back issues one
//  result per cycle or retires an interval without a result; a result passes
//  the stage registers s0 to s4 and then the output register after issue.
//  Reset: clears history, position and pipeline valids; rate_step returns to
//  1.0. Stalls: a full output register freezes the back pipeline, the job
//  queue holds the front off only when full.
//
module hermite_audio_resampler import har_pkg::*; #(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    har_in_if.sink            samples,
    har_out_if.source         results,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data
);

    localparam int DATA_W  = job_data_w(SAMPLE_BITS);
    localparam int JOB_W   = JOB_CTL_W + DATA_W;
    localparam int P_W     = pos_w(FRAC_BITS);
    localparam logic [P_W-1:0] ONE_POS = P_W'(1) << FRAC_BITS;

    logic [STEP_W-1:0] rate_step_reg;

    // front side of the queue
    logic              f_valid, f_ready;
    job_ctl_t          f_ctl;
    logic [DATA_W-1:0] f_data;

    // back side of the queue
    logic              b_valid, b_ready;
    job_ctl_t          b_ctl;
    logic [DATA_W-1:0] b_data;
    logic [JOB_W-1:0]  q_out;

    // rate register: to be written only while the block is idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_step_reg <= ONE_POS[STEP_W-1:0];
        end
        else if (cfg_wr_en)
        begin
            rate_step_reg <= cfg_wr_data;
        end
    end

    // front: take samples, build one job per interval that must be walked
    har_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job_ctl   (f_ctl),
        .job_data  (f_data)
    );

    // hold jobs so the front keeps taking samples while the back drains
    har_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_ctl, f_data}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (q_out)
    );

    assign b_ctl  = q_out[JOB_W-1 -: JOB_CTL_W];
    assign b_data = q_out[DATA_W-1:0];

    // back: advance the position, evaluate, saturate, present results
    har_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rate_step (rate_step_reg),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job_ctl   (b_ctl),
        .job_data  (b_data),
        .results   (results)
    );

endmodule

// ----- tb/resample_check_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resample_check_pkg: expected-result tracking for the Hermite resampler bench
// Holds a bit-exact fixed-point copy of the resampler's behavior and the queue
// of result beats it predicts, and compares each result beat against it.
// ----------------------------------------------------------------------------
package resample_check_pkg;

    import har_pkg::*;

    localparam int SW        = SAMPLE_BITS_DEF;
    localparam int FW        = FRAC_BITS_DEF;
    localparam int T_LIM     = (56 - SW) / 2;
    localparam int T_FRAC    = (FW < T_LIM) ? FW : T_LIM;
    localparam longint ONE_POS  = 64'sd1 <<< FW;
    localparam longint MIN_STEP = (ONE_POS + MAX_UPSAMPLE_DEF - 1) / MAX_UPSAMPLE_DEF;
    localparam longint T_SCALE  = 64'sd1 <<< T_FRAC;
    localparam longint SMP_MAX  = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SMP_MIN  = -SMP_MAX - 1;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 last;
    } out_beat_t;

    class resample_scoreboard;

        logic [STEP_W-1:0] step_reg;
        longint            hist[4];     // newest first
        longint            position;
        int                seen;
        out_beat_t         expected_q[$];
        int                n_predicted;
        int                n_checked;
        int                n_errors;

        function new();
            step_reg    = STEP_W'(ONE_POS);
            n_predicted = 0;
            n_checked   = 0;
            n_errors    = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            foreach (hist[i]) hist[i] = 0;
            position = 0;
            seen     = 0;
        endfunction

        function void set_step(logic [STEP_W-1:0] value);
            step_reg = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // round half up: floor((v + 2^(s-1)) / 2^s)
        function longint round_hu(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint interpolate(longint l, longint h, longint r, longint f, longint t);
            longint k1, k2, k3, a1, a2, y;
            k1 = r - l;
            k2 = 2 * l - 5 * h + 4 * r - f;
            k3 = (f - l) + 3 * (h - r);
            a1 = k3 * t + k2 * T_SCALE;
            a2 = round_hu(a1 * t, T_FRAC) + k1 * T_SCALE;
            y  = h + round_hu(a2 * t, 2 * T_FRAC + 1);
            if (y > SMP_MAX) y = SMP_MAX;
            if (y < SMP_MIN) y = SMP_MIN;
            return y;
        endfunction

        // emit every output whose integer position is d samples behind the newest
        function void emit_interval(int d);
            longint step, here, left, right, far, y;
            out_beat_t b;
            step = longint'(step_reg);
            if (step < MIN_STEP) step = MIN_STEP;
            here  = hist[d];
            left  = (d + 1 <= seen) ? hist[d + 1] : here;
            right = (d >= 1) ? hist[d - 1] : here;
            far   = (d >= 2) ? hist[d - 2] : right;
            while (position < ONE_POS) begin
                y = interpolate(left, here, right, far, position >>> (FW - T_FRAC));
                b.sample = y[SW-1:0];
                b.last   = 1'b0;
                expected_q.push_back(b);
                n_predicted++;
                position += step;
            end
            position -= ONE_POS;
        endfunction

        function void note_sample(logic signed [SW-1:0] x, logic eob);
            int q_start;
            q_start = expected_q.size();
            hist[3] = hist[2];
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = longint'(x);
            if (!eob) begin
                if (seen >= 2) emit_interval(2);
                if (seen < 3) seen++;
            end else begin
                for (int k = (seen >= 2) ? 2 : seen; k >= 0; k--)
                    emit_interval(k);
                clear_buffer();
            end
            if (expected_q.size() > q_start)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_output(logic signed [SW-1:0] got_sample, logic got_last);
            out_beat_t want;
            n_checked++;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_MAX)
                    $display("mismatch %0d: unexpected result beat, sample %0d last %0b",
                             n_errors, got_sample, got_last);
                return;
            end
            want = expected_q.pop_front();
            if (got_sample !== want.sample || got_last !== want.last) begin
                n_errors++;
                if (n_errors <= REPORT_MAX)
                    $display({"mismatch %0d at result %0d: expected sample %0d last %0b,",
                              " got sample %0d last %0b"},
                             n_errors, n_checked, want.sample, want.last,
                             got_sample, got_last);
            end
        endfunction

    endclass

endpackage

// ----- tb/tb_hermite_audio_resampler.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hermite_audio_resampler: self-checking bench for the Hermite resampler
// Drives buffers of audio samples through the valid/ready input stream under
// a range of rate_step settings and flow-control patterns, predicts every
// output beat in fixed point and checks each one as it leaves the block.
// ----------------------------------------------------------------------------
module tb_hermite_audio_resampler;

    import har_pkg::*;
    import resample_check_pkg::*;

    // flow-control patterns applied to both streams
    typedef enum int {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SINK_STALL,
        PACE_BOTH
    } pace_e;

    localparam int RESET_CYCLES      = 12;
    localparam int SETTLE_CYCLES     = 32;   // drain margin for jobs without output
    localparam int QUIET_LIMIT       = 4000; // cycles without any beat before giving up
    localparam int PHASE_ITEMS       = 40;

    logic clk;
    logic rst_n;
    logic              cfg_wr_en;
    logic [STEP_W-1:0] cfg_wr_data;

    har_in_if  #(.SAMPLE_BITS(SW)) samples_ch ();
    har_out_if #(.SAMPLE_BITS(SW)) results_ch ();

    hermite_audio_resampler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_ch),
        .results     (results_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    resample_scoreboard sb;

    int src_idle_pct;
    int sink_stall_pct;
    int n_sent;
    int n_step_writes;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Result side: set ready at random at the falling edge, take beats at the
    // rising edge and hand them to the scoreboard.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        results_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
            sb.check_output(results_ch.out_sample, results_ch.run_last);
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no beat moves on either stream and
    // no register write happens; a hung block ends the run here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (samples_ch.valid && samples_ch.ready) ||
            (results_ch.valid && results_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic set_pacing(input pace_e pace);
        begin
            case (pace)
                PACE_FREE:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                PACE_SRC_IDLE:   begin src_idle_pct = 62; sink_stall_pct = 0;  end
                PACE_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default:         begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
        end
    endtask

    // Present one sample beat and hold it until the block takes it. Leave
    // valid high on return so back-to-back beats can follow without a gap.
    task automatic send_sample(input logic signed [SW-1:0] value, input logic eob);
        begin
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct)
            begin
                samples_ch.valid <= 1'b0;
                @(negedge clk);
            end
            samples_ch.valid         <= 1'b1;
            samples_ch.in_sample     <= value;
            samples_ch.end_of_buffer <= eob;
            do @(posedge clk); while (!samples_ch.ready);
            sb.note_sample(value, eob);
            n_sent++;
        end
    endtask

    // Drop valid, wait for every predicted beat, then give the back end
    // time to retire intervals that produce no output.
    task automatic settle_pipeline();
        begin
            @(negedge clk);
            samples_ch.valid <= 1'b0;
            while (sb.pending() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Write rate_step only with the block fully idle.
    task automatic write_step(input logic [STEP_W-1:0] value);
        begin
            settle_pipeline();
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            sb.set_step(value);
            n_step_writes++;
        end
    endtask

    function automatic logic signed [SW-1:0] rnd_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(7))
            0:       v = {1'b0, {(SW-1){1'b1}}};
            1:       v = {1'b1, {(SW-1){1'b0}}};
            2:       v = SW'(int'($urandom_range(63)) - 32);
            default: v = SW'($urandom);
        endcase
        return v;
    endfunction

    // Mostly full-length buffers; now and then a one- to three-sample one
    // to hit the edge replication paths.
    function automatic int pick_len();
        return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
    endfunction

    // One random phase: set the step, set the pacing, stream buffers. Pause
    // halfway until the block has delivered everything. Close on a buffer
    // boundary with the last item of the phase.
    task automatic run_phase(input logic [STEP_W-1:0] step, input pace_e pace, input int n);
        int   sent;
        int   buf_left;
        logic eob;
        logic wrap;
        begin
            write_step(step);
            set_pacing(pace);
            sent     = 0;
            buf_left = 0;
            forever
            begin
                wrap = (sent >= n - 1);
                if (buf_left == 0)
                    buf_left = pick_len();
                buf_left--;
                eob = (buf_left == 0) || wrap;
                if (eob)
                    buf_left = 0;
                if (sent == n / 2)
                    settle_pipeline();
                send_sample(rnd_sample(), eob);
                sent++;
                if (wrap)
                    break;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        n_sent        = 0;
        n_step_writes = 0;
        rst_n                    = 1'b0;
        cfg_wr_en                = 1'b0;
        cfg_wr_data              = '0;
        samples_ch.valid         = 1'b0;
        samples_ch.in_sample     = '0;
        samples_ch.end_of_buffer = 1'b0;
        set_pacing(PACE_FREE);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: short buffers at the reset step of 1.0 exercise the
        // start and end replication with one, two and three samples.
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);

        // Directed: half-sample step over min/max/max/min pairs drives the
        // cubic past full scale in both directions, so the output clips.
        write_step(24'd32768);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // Directed: zero step clamps to the minimum; the end of this buffer
        // flushes three full intervals at the upsample limit.
        write_step(24'd0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd200, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // Random phases over step settings and flow-control patterns.
        run_phase(24'd65536, PACE_FREE, PHASE_ITEMS);
        run_phase(24'd4096, PACE_SRC_IDLE, PHASE_ITEMS);
        run_phase(24'hFFFFFF, PACE_SINK_STALL, PHASE_ITEMS);
        run_phase(24'd43690, PACE_BOTH, PHASE_ITEMS);
        run_phase(STEP_W'($urandom_range(4096, 200000)), PACE_FREE, PHASE_ITEMS);
        run_phase(24'd4095, PACE_SRC_IDLE, PHASE_ITEMS);
        run_phase(STEP_W'($urandom_range(0, 1 << 20)), PACE_SINK_STALL, PHASE_ITEMS);
        run_phase(24'd98304, PACE_BOTH, PHASE_ITEMS);

        settle_pipeline();

        $display("covered %0d sample beats and %0d result beats across %0d rate_step settings",
                 n_sent, sb.n_checked, n_step_writes + 1);
        $display("flow patterns: free, idle source, stalled sink, both; mismatches: %0d",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/har_pkg.sv
hdl/har_if.sv
hdl/har_front.sv
hdl/har_queue.sv
hdl/har_back.sv
hdl/hermite_audio_resampler.sv
tb/resample_check_pkg.sv
tb/tb_hermite_audio_resampler.sv
